[sv/fmap_pkg.sv]
// Package for the half-precision multipass average pool.
// Holds payload structs, config codes and half-precision arithmetic functions.
// No dependencies.
package fmap_pkg;

	localparam int DefMaxChannels = 256;
	localparam int CountW = 9;
	localparam int HalfW = 16;
	localparam int CfgIdxW = 2;

	localparam logic [HalfW-1:0] HalfQnan = 16'h7E00;
	localparam logic [CountW-1:0] RstCount = 9'd1;
	localparam logic [HalfW-1:0] RstMin = 16'hFBFF;
	localparam logic [HalfW-1:0] RstMax = 16'h7BFF;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CfgChannelCount = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgOutputMin = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgOutputMax = 2'd2;

	// pass kinds
	localparam logic [1:0] ReqFirst = 2'd0;
	localparam logic [1:0] ReqMiddle = 2'd1;
	localparam logic [1:0] ReqLast = 2'd2;
	localparam logic [1:0] ReqNone = 2'd3;

	typedef struct packed {
		logic [1:0] req_type;
		logic [15:0] tap0;
		logic [15:0] tap1;
		logic [15:0] tap2;
		logic [15:0] tap3;
		logic [15:0] tap4;
		logic [15:0] tap5;
		logic [15:0] tap6;
		logic [15:0] tap7;
		logic [15:0] tap8;
		logic [15:0] scale;
	} in_t;

	typedef struct packed {
		logic [15:0] pooled_value;
		logic last_channel;
	} out_t;

	typedef struct packed {
		logic [CountW-1:0] channel_count;
		logic [HalfW-1:0] output_min;
		logic [HalfW-1:0] output_max;
	} cfg_t;

	function automatic logic h_is_nan(logic [15:0] h);
		return (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
	endfunction

	function automatic logic h_is_inf(logic [15:0] h);
		return h[14:0] == 15'h7C00;
	endfunction

	// round sign * mag * 2^exp2 to half, nearest even
	function automatic logic [15:0] h_pack(logic sign, logic [63:0] mag, int exp2);
		int p;
		int lsb;
		int sh;
		int bexp;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] half;
		logic [15:0] r;
		p = 0;
		q = '0;
		for (int i = 0; i < 64; i++) begin
			if (mag[i]) p = i;
		end
		lsb = p + exp2 - 10;
		if (lsb < -24) lsb = -24;
		sh = lsb - exp2;
		if (sh <= 0) begin
			q = mag << (-sh);
		end else if (sh > 62) begin
			q = '0;
		end else begin
			rem = mag & ((64'd1 << sh) - 64'd1);
			half = 64'd1 << (sh - 1);
			q = mag >> sh;
			if (rem > half || (rem == half && q[0])) q = q + 64'd1;
		end
		if (q >= 64'd2048) begin
			q = q >> 1;
			lsb = lsb + 1;
		end
		bexp = lsb + 25;
		if (mag == 64'd0) r = {sign, 15'd0};
		else if (q < 64'd1024) r = {sign, 5'd0, q[9:0]};
		else if (bexp >= 31) r = {sign, 15'h7C00};
		else r = {sign, 5'(bexp), q[9:0]};
		return r;
	endfunction

	function automatic logic [15:0] h_add(logic [15:0] a, logic [15:0] b);
		logic [63:0] ma;
		logic [63:0] mb;
		int ea;
		int eb;
		logic signed [63:0] va;
		logic signed [63:0] vb;
		logic signed [63:0] s;
		logic [15:0] r;
		ma = (a[14:10] == 5'd0) ? {54'd0, a[9:0]} : {53'd0, 1'b1, a[9:0]};
		mb = (b[14:10] == 5'd0) ? {54'd0, b[9:0]} : {53'd0, 1'b1, b[9:0]};
		ea = (a[14:10] == 5'd0) ? 1 : int'(a[14:10]);
		eb = (b[14:10] == 5'd0) ? 1 : int'(b[14:10]);
		va = $signed(ma << (ea - 1));
		vb = $signed(mb << (eb - 1));
		if (a[15]) va = -va;
		if (b[15]) vb = -vb;
		s = va + vb;
		if (h_is_nan(a) || h_is_nan(b)) r = HalfQnan;
		else if (h_is_inf(a) && h_is_inf(b)) r = (a[15] == b[15]) ? a : HalfQnan;
		else if (h_is_inf(a)) r = a;
		else if (h_is_inf(b)) r = b;
		else if (s == 64'sd0) r = {a[15] & b[15], 15'd0};
		else if (s < 64'sd0) r = h_pack(1'b1, 64'(-s), -24);
		else r = h_pack(1'b0, 64'(s), -24);
		return r;
	endfunction

	function automatic logic [15:0] h_mul(logic [15:0] a, logic [15:0] b);
		logic sign;
		logic [10:0] ma;
		logic [10:0] mb;
		logic [21:0] prod;
		int ea;
		int eb;
		logic za;
		logic zb;
		logic [15:0] r;
		sign = a[15] ^ b[15];
		za = a[14:0] == 15'd0;
		zb = b[14:0] == 15'd0;
		ma = (a[14:10] == 5'd0) ? {1'b0, a[9:0]} : {1'b1, a[9:0]};
		mb = (b[14:10] == 5'd0) ? {1'b0, b[9:0]} : {1'b1, b[9:0]};
		ea = (a[14:10] == 5'd0) ? 1 : int'(a[14:10]);
		eb = (b[14:10] == 5'd0) ? 1 : int'(b[14:10]);
		// full-width significand product
		prod = {11'd0, ma} * {11'd0, mb};
		if (h_is_nan(a) || h_is_nan(b)) r = HalfQnan;
		else if (h_is_inf(a) || h_is_inf(b)) r = (za || zb) ? HalfQnan : {sign, 15'h7C00};
		else if (za || zb) r = {sign, 15'd0};
		else r = h_pack(sign, {42'd0, prod}, ea + eb - 50);
		return r;
	endfunction

	// ordering key; -0 sorts below +0
	function automatic logic signed [16:0] h_key(logic [15:0] h);
		logic signed [16:0] m;
		m = $signed({2'b00, h[14:0]});
		return h[15] ? (-m - 17'sd1) : m;
	endfunction

	function automatic logic [15:0] h_clamp(logic [15:0] v, logic [15:0] lo, logic [15:0] hi);
		logic [15:0] t;
		logic [15:0] r;
		if (h_is_nan(v) || h_is_nan(lo)) t = HalfQnan;
		else t = (h_key(v) >= h_key(lo)) ? v : lo;
		if (h_is_nan(t) || h_is_nan(hi)) r = HalfQnan;
		else r = (h_key(t) <= h_key(hi)) ? t : hi;
		return r;
	endfunction

endpackage

[sv/fp16_multipass_average_pool_top.sv]
// Top level of the half-precision multipass average pool.
// Depends on fmap_pkg, fmap_acc_ram and fmap_chan_ctrl.
//
//  channel | handshake           | payload
//  in      | in_valid/in_ready   | in_data (in_t)
//  out     | out_valid/out_ready | out_data (out_t)
//  cfg     | cfg_we              | cfg_index, cfg_wdata
//
// One item per cycle unless a channel hazard or a held output stalls the input.
// An item on a channel that still has a write back in stages one to four waits,
// so with fewer than five channels an item waits until that channel's write back
// has left stage four; with a count of one each item waits on the one before it.
// Reset clears control state, loads default config; accumulators unset until written.
// A held result stalls the pipe only when the next result is ready behind it.
module fp16_multipass_average_pool_top import fmap_pkg::*; #(
	parameter int MAX_CHANNELS = DefMaxChannels
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data,
	input  logic cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [HalfW-1:0] cfg_wdata
);

	localparam int PosW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	cfg_t cfg;
	logic [PosW-1:0] pos;
	logic last;
	logic adv;
	logic hazard;
	logic acc_in;
	logic take;
	logic [HalfW-1:0] rd;
	logic [HalfW-1:0] sum_s4;

	// stage valid, write-back flag, position, last flag
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic wr_s1, wr_s2, wr_s3, wr_s4;
	logic [PosW-1:0] pos_s1, pos_s2, pos_s3, pos_s4;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;
	logic [HalfW-1:0] scale_s1, scale_s2, scale_s3, scale_s4, scale_s5;
	logic first_s1;
	logic [HalfW-1:0] t0_s1, t1_s1, t2_s1, t3_s1, t4_s1, t5_s1, t6_s1, t7_s1, t8_s1;
	logic [HalfW-1:0] s01_s2, s23_s2, s45_s2, s67_s2, acc_s2;
	logic [HalfW-1:0] s2345_s3, a_s3, s67_s3;
	logic [HalfW-1:0] s2345_s4, b_s4;
	logic [HalfW-1:0] sum_s5;
	logic [HalfW-1:0] prod_s6;
	logic out_valid_q;
	out_t out_q;

	// freeze only when a result waits behind a held one
	assign adv = !(v_s6 && out_valid_q && !out_ready);
	assign hazard = (v_s1 && wr_s1 && pos_s1 == pos) || (v_s2 && wr_s2 && pos_s2 == pos)
		|| (v_s3 && wr_s3 && pos_s3 == pos) || (v_s4 && wr_s4 && pos_s4 == pos);
	assign in_ready = adv && !hazard;
	assign acc_in = in_valid && in_ready;
	assign take = acc_in && (in_data.req_type != ReqNone);

	fmap_chan_ctrl #(
		.MaxChannels(MAX_CHANNELS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.step(take),
		.cfg(cfg),
		.pos(pos),
		.last(last)
	);

	assign sum_s4 = h_add(s2345_s4, b_s4);

	fmap_acc_ram #(
		.Depth(MAX_CHANNELS)
	) u_ram (
		.clk(clk),
		.we(adv && v_s4 && wr_s4),
		.waddr(pos_s4),
		.wdata(sum_s4),
		.re(take),
		.raddr(pos),
		.rdata(rd)
	);

	// advance control of the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4 && !wr_s4;
			v_s6 <= v_s5;
		end
	end

	// datapath stages: input capture, leaf adds, accumulator and tree adds, two more tree adds, scale
	always_ff @(posedge clk) begin
		if (adv) begin
			wr_s1 <= in_data.req_type != ReqLast;
			first_s1 <= in_data.req_type == ReqFirst;
			pos_s1 <= pos;
			last_s1 <= last;
			scale_s1 <= in_data.scale;
			t0_s1 <= in_data.tap0;
			t1_s1 <= in_data.tap1;
			t2_s1 <= in_data.tap2;
			t3_s1 <= in_data.tap3;
			t4_s1 <= in_data.tap4;
			t5_s1 <= in_data.tap5;
			t6_s1 <= in_data.tap6;
			t7_s1 <= in_data.tap7;
			t8_s1 <= in_data.tap8;

			wr_s2 <= wr_s1;
			pos_s2 <= pos_s1;
			last_s2 <= last_s1;
			scale_s2 <= scale_s1;
			s01_s2 <= h_add(t0_s1, t1_s1);
			s23_s2 <= h_add(t2_s1, t3_s1);
			s45_s2 <= h_add(t4_s1, t5_s1);
			s67_s2 <= h_add(t6_s1, t7_s1);
			acc_s2 <= first_s1 ? t8_s1 : rd;

			wr_s3 <= wr_s2;
			pos_s3 <= pos_s2;
			last_s3 <= last_s2;
			scale_s3 <= scale_s2;
			s2345_s3 <= h_add(s23_s2, s45_s2);
			a_s3 <= h_add(s01_s2, acc_s2);
			s67_s3 <= s67_s2;

			wr_s4 <= wr_s3;
			pos_s4 <= pos_s3;
			last_s4 <= last_s3;
			scale_s4 <= scale_s3;
			s2345_s4 <= s2345_s3;
			b_s4 <= h_add(a_s3, s67_s3);

			last_s5 <= last_s4;
			scale_s5 <= scale_s4;
			sum_s5 <= sum_s4;

			last_s6 <= last_s5;
			prod_s6 <= h_mul(sum_s5, scale_s5);
		end
	end

	// output register: load a clamped result, drop it on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (v_s6 && adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s6 && adv) begin
			out_q.pooled_value <= h_clamp(prod_s6, cfg.output_min, cfg.output_max);
			out_q.last_channel <= last_s6;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// no read of a channel whose write back is still pending in stage four
	a_no_raw: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !(v_s4 && wr_s4 && pos_s4 == pos))
		else $error("accumulator read overlaps pending write");

	// a frozen result stage keeps its product
	a_hold_s6: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && !adv) |=> (v_s6 && $stable(prod_s6)))
		else $error("result stage lost while stalled");

	// a held output is never overwritten
	a_out_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_q)))
		else $error("held output changed");

endmodule

[sv/fmap_acc_ram.sv]
// Per-channel accumulator memory: one write port, one registered read port.
// Depends on fmap_pkg.
module fmap_acc_ram import fmap_pkg::*; #(
	parameter int Depth = DefMaxChannels,
	parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic clk,
	input  logic we,
	input  logic [AddrW-1:0] waddr,
	input  logic [HalfW-1:0] wdata,
	input  logic re,
	input  logic [AddrW-1:0] raddr,
	output logic [HalfW-1:0] rdata
);

	logic [HalfW-1:0] mem [Depth];

	// write back updated sums
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// read on transfer, hold otherwise
	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end

endmodule

[sv/fmap_chan_ctrl.sv]
// Configuration registers and channel position counter.
// Depends on fmap_pkg.
module fmap_chan_ctrl import fmap_pkg::*; #(
	parameter int MaxChannels = DefMaxChannels,
	parameter int PosW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [HalfW-1:0] cfg_wdata,
	input  logic step,
	output cfg_t cfg,
	output logic [PosW-1:0] pos,
	output logic last
);

	localparam int CntW = $clog2(MaxChannels + 1);
	localparam int ExtW = (CntW > CountW) ? CntW + 1 : CountW + 1;

	cfg_t cfg_q;
	logic [PosW-1:0] pos_q;
	logic [ExtW-1:0] cnt_raw;
	logic [ExtW-1:0] cnt_eff;
	logic [ExtW-1:0] pos_ext;

	assign cfg = cfg_q;

	// take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_count <= RstCount;
			cfg_q.output_min <= RstMin;
			cfg_q.output_max <= RstMax;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgChannelCount: cfg_q.channel_count <= cfg_wdata[CountW-1:0];
				CfgOutputMin: cfg_q.output_min <= cfg_wdata;
				CfgOutputMax: cfg_q.output_max <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// clamp count, restart position when beyond it
	always_comb begin
		cnt_raw = ExtW'(cfg_q.channel_count);
		if (cnt_raw == '0) cnt_eff = ExtW'(1);
		else if (cnt_raw > ExtW'(MaxChannels)) cnt_eff = ExtW'(MaxChannels);
		else cnt_eff = cnt_raw;
		pos_ext = (ExtW'(pos_q) >= cnt_eff) ? '0 : ExtW'(pos_q);
		pos = pos_ext[PosW-1:0];
		last = pos_ext == (cnt_eff - ExtW'(1));
	end

	// advance and wrap on each pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (step) begin
			pos_q <= last ? '0 : PosW'(pos_ext + ExtW'(1));
		end
	end

endmodule
